FILE: sv/complex_arithmetic_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cau assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cau assertion failed");

`endif

FILE: sv/cau_pkg.sv
// Types, codes and product sequences of the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned EXP_W  = 6;
	localparam int unsigned ACT_W  = 3;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned STEP_W = 3;

	localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
	localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
	localparam logic [ACT_W-1:0] ACT_MAG = 3'd4;
	localparam logic [ACT_W-1:0] ACT_POW = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_DIV_ZERO  = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

	typedef enum logic [1:0] {OPD_XR, OPD_XI, OPD_YR, OPD_YI} opd_sel_t;

	typedef enum logic [3:0] {
		ACC_NONE, ACC_RE_SET, ACC_RE_ADD, ACC_RE_SUB,
		ACC_IM_SET, ACC_IM_ADD, ACC_IM_SUB, ACC_D_SET, ACC_D_ADD
	} acc_op_t;

	typedef enum logic [1:0] {SEQ_CMUL, SEQ_CDIV, SEQ_MAG} seq_kind_t;

	typedef struct packed {
		opd_sel_t opa;
		opd_sel_t opb;
		acc_op_t  acc;
	} prod_step_t;

	typedef struct packed {
		logic       load;
		logic       load_pow;
		logic       addsub;
		logic       addsub_sub;
		logic       set_one;
		logic       clear;
		prod_step_t step;
		logic       round;
		logic       recip;
		logic       div_start;
		logic       div_step;
		logic       div_write;
		logic       div_part_im;
		logic       sqrt_start;
		logic       sqrt_step;
		logic       sqrt_write;
		logic       set_dz;
		logic       emit;
	} cau_cmd_t;

	typedef struct packed {
		logic d_zero;
	} cau_stat_t;

	function automatic logic [STEP_W-1:0] seq_len(input seq_kind_t kind);
		logic [STEP_W-1:0] n;
		unique case (kind)
			SEQ_CMUL: n = 3'd4;
			SEQ_CDIV: n = 3'd6;
			SEQ_MAG:  n = 3'd2;
			default:  n = 3'd0;
		endcase
		return n;
	endfunction

	// Multiplier program: operand pair and where the product is accumulated.
	function automatic prod_step_t prod_step(input seq_kind_t kind, input logic [STEP_W-1:0] idx);
		prod_step_t s;
		s = '{opa: OPD_XR, opb: OPD_XR, acc: ACC_NONE};
		unique case (kind)
			SEQ_CMUL: begin
				unique case (idx)
					3'd0: s = '{opa: OPD_XR, opb: OPD_YR, acc: ACC_RE_SET};
					3'd1: s = '{opa: OPD_XI, opb: OPD_YI, acc: ACC_RE_SUB};
					3'd2: s = '{opa: OPD_XR, opb: OPD_YI, acc: ACC_IM_SET};
					3'd3: s = '{opa: OPD_XI, opb: OPD_YR, acc: ACC_IM_ADD};
					default: ;
				endcase
			end
			SEQ_CDIV: begin
				unique case (idx)
					3'd0: s = '{opa: OPD_YR, opb: OPD_YR, acc: ACC_D_SET};
					3'd1: s = '{opa: OPD_YI, opb: OPD_YI, acc: ACC_D_ADD};
					3'd2: s = '{opa: OPD_XR, opb: OPD_YR, acc: ACC_RE_SET};
					3'd3: s = '{opa: OPD_XI, opb: OPD_YI, acc: ACC_RE_ADD};
					3'd4: s = '{opa: OPD_XI, opb: OPD_YR, acc: ACC_IM_SET};
					3'd5: s = '{opa: OPD_XR, opb: OPD_YI, acc: ACC_IM_SUB};
					default: ;
				endcase
			end
			SEQ_MAG: begin
				unique case (idx)
					3'd0: s = '{opa: OPD_XR, opb: OPD_XR, acc: ACC_D_SET};
					3'd1: s = '{opa: OPD_XI, opb: OPD_XI, acc: ACC_D_ADD};
					default: ;
				endcase
			end
			default: ;
		endcase
		return s;
	endfunction

endpackage

FILE: sv/cau_datapath.sv
// Datapath: operand registers, shared multiplier, accumulators, divider and square root.
`timescale 1ns / 1ps

module cau_datapath import cau_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cau_cmd_t                 cmd,
	output cau_stat_t                stat,
	input  logic signed [WORD_W-1:0] a_re,
	input  logic signed [WORD_W-1:0] a_im,
	input  logic signed [WORD_W-1:0] b_re,
	input  logic signed [WORD_W-1:0] b_im,
	output logic signed [WORD_W-1:0] r_re,
	output logic signed [WORD_W-1:0] r_im,
	output logic [STAT_W-1:0]        status
);

	localparam int unsigned NUM_W = 64 + FRAC_BITS;
	localparam logic [WORD_W-1:0] ONE = WORD_W'(64'd1 << FRAC_BITS);

	logic signed [WORD_W-1:0] x_re_q, x_im_q, y_re_q, y_im_q;
	logic signed [WORD_W-1:0] mul_a, mul_b;
	logic signed [63:0]       prod_c, prod_q;
	acc_op_t                  acc_pend_q;
	logic signed [64:0]       acc_re_q, acc_im_q, prod_ext;
	logic [63:0]              acc_d_q;
	logic                     ovf_q, dz_q;

	logic [NUM_W-1:0]         num_q;
	logic [63:0]              rem_q;
	logic [32:0]              quo_q;
	logic                     big_q, neg_q;

	logic [63:0]              sq_v_q, sq_res_q, sq_bit_q, sq_t;

	logic signed [WORD_W-1:0] r_re_q, r_im_q;
	logic [STAT_W-1:0]        status_q;

	logic signed [WORD_W:0]   sum_re, sum_im;
	logic [WORD_W:0]          sat_re, sat_im, rnd_re, rnd_im, div_res, sq_res;
	logic [64:0]              div_r2, div_diff;
	logic                     div_ge, div_up;
	logic signed [64:0]       div_src;
	logic [63:0]              div_abs;
	logic [33:0]              div_q1;

	// {overflow, value}: clamp a magnitude to the 32-bit range and apply the sign
	function automatic logic [WORD_W:0] sat_mag(input logic [63:0] mag, input logic neg);
		logic [63:0]       lim;
		logic [WORD_W-1:0] m;
		logic              over;
		lim  = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
		over = mag > lim;
		m    = over ? lim[WORD_W-1:0] : mag[WORD_W-1:0];
		return {over, neg ? (WORD_W'(0) - m) : m};
	endfunction

	function automatic logic [63:0] abs65(input logic signed [64:0] v);
		logic [64:0] n;
		n = v[64] ? (65'd0 - v) : v;
		return n[63:0];
	endfunction

	function automatic logic [WORD_W:0] shift_round(input logic signed [64:0] v);
		logic [63:0] m, q;
		m = abs65(v);
		q = (m >> FRAC_BITS) + 64'(m[FRAC_BITS-1]);
		return sat_mag(q, v[64]);
	endfunction

	function automatic logic [WORD_W:0] sat_sum(input logic signed [WORD_W:0] s);
		logic over;
		over = s[WORD_W] != s[WORD_W-1];
		if (over)
			return {1'b1, s[WORD_W] ? 32'h8000_0000 : 32'h7fff_ffff};
		return {1'b0, s[WORD_W-1:0]};
	endfunction

	always_comb begin
		unique case (cmd.step.opa)
			OPD_XR:  mul_a = x_re_q;
			OPD_XI:  mul_a = x_im_q;
			OPD_YR:  mul_a = y_re_q;
			default: mul_a = y_im_q;
		endcase
		unique case (cmd.step.opb)
			OPD_XR:  mul_b = x_re_q;
			OPD_XI:  mul_b = x_im_q;
			OPD_YR:  mul_b = y_re_q;
			default: mul_b = y_im_q;
		endcase
	end

	assign prod_c   = mul_a * mul_b;
	assign prod_ext = 65'(prod_q);

	assign sum_re = cmd.addsub_sub ? (33'(x_re_q) - 33'(y_re_q)) : (33'(x_re_q) + 33'(y_re_q));
	assign sum_im = cmd.addsub_sub ? (33'(x_im_q) - 33'(y_im_q)) : (33'(x_im_q) + 33'(y_im_q));
	assign sat_re = sat_sum(sum_re);
	assign sat_im = sat_sum(sum_im);

	assign rnd_re = shift_round(acc_re_q);
	assign rnd_im = shift_round(acc_im_q);

	// Restoring division, one quotient bit a step
	assign div_src  = cmd.div_part_im ? acc_im_q : acc_re_q;
	assign div_abs  = abs65(div_src);
	assign div_r2   = {rem_q, num_q[NUM_W-1]};
	assign div_diff = div_r2 - {1'b0, acc_d_q};
	assign div_ge   = div_r2 >= {1'b0, acc_d_q};
	assign div_up   = {rem_q, 1'b0} >= {1'b0, acc_d_q};
	assign div_q1   = 34'(quo_q) + 34'(div_up);
	assign div_res  = sat_mag(big_q ? 64'hffff_ffff_ffff_ffff : 64'(div_q1), neg_q);

	assign sq_t   = sq_res_q + sq_bit_q;
	assign sq_res = sat_mag(sq_res_q, 1'b0);

	assign stat.d_zero = acc_d_q == 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_pend_q <= ACC_NONE;
			ovf_q      <= 1'b0;
			dz_q       <= 1'b0;
		end else begin
			acc_pend_q <= cmd.step.acc;
			if (cmd.load) begin
				ovf_q <= 1'b0;
				dz_q  <= 1'b0;
			end else begin
				if (cmd.set_dz)
					dz_q <= 1'b1;
				if ((cmd.addsub && (sat_re[WORD_W] || sat_im[WORD_W])) ||
				    (cmd.round && (rnd_re[WORD_W] || rnd_im[WORD_W])) ||
				    (cmd.div_write && div_res[WORD_W]) ||
				    (cmd.sqrt_write && sq_res[WORD_W]))
					ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_c;

		unique case (acc_pend_q)
			ACC_RE_SET: acc_re_q <= prod_ext;
			ACC_RE_ADD: acc_re_q <= acc_re_q + prod_ext;
			ACC_RE_SUB: acc_re_q <= acc_re_q - prod_ext;
			ACC_IM_SET: acc_im_q <= prod_ext;
			ACC_IM_ADD: acc_im_q <= acc_im_q + prod_ext;
			ACC_IM_SUB: acc_im_q <= acc_im_q - prod_ext;
			ACC_D_SET:  acc_d_q  <= prod_q;
			ACC_D_ADD:  acc_d_q  <= acc_d_q + prod_q;
			default: ;
		endcase

		priority if (cmd.load) begin
			x_re_q <= a_re;
			x_im_q <= a_im;
			y_re_q <= cmd.load_pow ? a_re : b_re;
			y_im_q <= cmd.load_pow ? a_im : b_im;
		end else if (cmd.addsub) begin
			x_re_q <= sat_re[WORD_W-1:0];
			x_im_q <= sat_im[WORD_W-1:0];
		end else if (cmd.set_one) begin
			x_re_q <= ONE;
			x_im_q <= '0;
		end else if (cmd.clear) begin
			x_re_q <= '0;
			x_im_q <= '0;
		end else if (cmd.round) begin
			x_re_q <= rnd_re[WORD_W-1:0];
			x_im_q <= rnd_im[WORD_W-1:0];
		end else if (cmd.recip) begin
			// reciprocal: 1.0 over the current power
			y_re_q <= x_re_q;
			y_im_q <= x_im_q;
			x_re_q <= ONE;
			x_im_q <= '0;
		end else if (cmd.div_write) begin
			if (cmd.div_part_im)
				x_im_q <= div_res[WORD_W-1:0];
			else
				x_re_q <= div_res[WORD_W-1:0];
		end else if (cmd.sqrt_write) begin
			x_re_q <= sq_res[WORD_W-1:0];
			x_im_q <= '0;
		end

		if (cmd.div_start) begin
			num_q <= {div_abs, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
			neg_q <= div_src[64];
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			rem_q <= div_ge ? div_diff[63:0] : div_r2[63:0];
			quo_q <= {quo_q[31:0], div_ge};
			big_q <= big_q | quo_q[32];
		end

		if (cmd.sqrt_start) begin
			sq_v_q   <= acc_d_q;
			sq_res_q <= '0;
			sq_bit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.sqrt_step) begin
			if (sq_v_q >= sq_t) begin
				sq_v_q   <= sq_v_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end

		if (cmd.emit) begin
			r_re_q   <= dz_q ? '0 : x_re_q;
			r_im_q   <= dz_q ? '0 : x_im_q;
			status_q <= dz_q ? ST_DIV_ZERO : (ovf_q ? ST_OVERFLOW : ST_OK);
		end
	end

	assign r_re   = r_re_q;
	assign r_im   = r_im_q;
	assign status = status_q;

endmodule

FILE: sv/cau_controller.sv
// Controller: sequences the datapath for each action and owns the stream handshakes.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_defines.svh"

module cau_controller import cau_pkg::*; #(
	parameter int unsigned MAX_EXPONENT = 31,
	parameter int unsigned FRAC_BITS    = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [ACT_W-1:0]       in_action,
	input  logic signed [EXP_W-1:0] in_exponent,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cau_cmd_t               cmd,
	input  cau_stat_t              stat
);

	localparam int unsigned DIV_STEPS  = 64 + FRAC_BITS;
	localparam int unsigned SQRT_STEPS = 32;
	localparam int unsigned CNT_W      = $clog2(DIV_STEPS + 1);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_ADDSUB = 16'h0002,
		S_ONE    = 16'h0004,
		S_CLEAR  = 16'h0008,
		S_PROD   = 16'h0010,
		S_ROUND  = 16'h0020,
		S_PPOST  = 16'h0040,
		S_RECIP  = 16'h0080,
		S_DCHK   = 16'h0100,
		S_DSTART = 16'h0200,
		S_DSTEP  = 16'h0400,
		S_DWRITE = 16'h0800,
		S_SSTART = 16'h1000,
		S_SSTEP  = 16'h2000,
		S_SWRITE = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	seq_kind_t         seq_q, seq_d;
	logic [ACT_W-1:0]  act_q, act_d;
	logic [EXP_W-1:0]  pow_rem_q, pow_rem_d;
	logic              exp_neg_q, exp_neg_d;
	logic              part_im_q, part_im_d;
	logic              out_valid_q;
	logic [EXP_W-1:0]  e_abs, e_mag;
	logic              accept;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	// |exponent|, clamped to the largest power supported
	assign e_abs = in_exponent[EXP_W-1] ? (EXP_W'(0) - in_exponent) : in_exponent;
	assign e_mag = (int'(e_abs) > int'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT) : e_abs;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		seq_d     = seq_q;
		act_d     = act_q;
		pow_rem_d = pow_rem_q;
		exp_neg_d = exp_neg_q;
		part_im_d = part_im_q;
		cmd       = '0;
		cmd.div_part_im = part_im_q;
		cmd.addsub_sub  = act_q == ACT_SUB;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load     = 1'b1;
					cmd.load_pow = in_action == ACT_POW;
					act_d        = in_action;
					exp_neg_d    = in_exponent[EXP_W-1];
					cnt_d        = '0;
					unique case (in_action)
						ACT_ADD, ACT_SUB: state_d = S_ADDSUB;
						ACT_MUL: begin
							seq_d   = SEQ_CMUL;
							state_d = S_PROD;
						end
						ACT_DIV: begin
							seq_d   = SEQ_CDIV;
							state_d = S_PROD;
						end
						ACT_MAG: begin
							seq_d   = SEQ_MAG;
							state_d = S_PROD;
						end
						ACT_POW: begin
							seq_d     = SEQ_CMUL;
							pow_rem_d = e_mag - EXP_W'(1);
							if (e_mag == '0)
								state_d = S_ONE;
							else if (e_mag == EXP_W'(1))
								state_d = S_PPOST;
							else
								state_d = S_PROD;
						end
						default: state_d = S_CLEAR;
					endcase
				end
			end
			S_ADDSUB: begin
				cmd.addsub = 1'b1;
				state_d    = S_DONE;
			end
			S_ONE: begin
				cmd.set_one = 1'b1;
				state_d     = S_DONE;
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = S_DONE;
			end
			S_PROD: begin
				// issue one product a cycle; each product is registered in prod_q before it is accumulated
				if (cnt_q < CNT_W'(seq_len(seq_q)))
					cmd.step = prod_step(seq_q, cnt_q[STEP_W-1:0]);
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(seq_len(seq_q))) begin
					cnt_d = '0;
					unique case (seq_q)
						SEQ_CMUL: state_d = S_ROUND;
						SEQ_CDIV: state_d = S_DCHK;
						default:  state_d = S_SSTART;
					endcase
				end
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (act_q != ACT_POW)
					state_d = S_DONE;
				else if (pow_rem_q == EXP_W'(1))
					state_d = S_PPOST;
				else begin
					pow_rem_d = pow_rem_q - EXP_W'(1);
					state_d   = S_PROD;
				end
			end
			S_PPOST: state_d = exp_neg_q ? S_RECIP : S_DONE;
			S_RECIP: begin
				cmd.recip = 1'b1;
				seq_d     = SEQ_CDIV;
				cnt_d     = '0;
				state_d   = S_PROD;
			end
			S_DCHK: begin
				part_im_d = 1'b0;
				if (stat.d_zero) begin
					cmd.set_dz = 1'b1;
					state_d    = S_DONE;
				end else begin
					state_d = S_DSTART;
				end
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				cnt_d         = '0;
				state_d       = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					state_d = S_DWRITE;
			end
			S_DWRITE: begin
				cmd.div_write = 1'b1;
				if (part_im_q)
					state_d = S_DONE;
				else begin
					part_im_d = 1'b1;
					state_d   = S_DSTART;
				end
			end
			S_SSTART: begin
				cmd.sqrt_start = 1'b1;
				cnt_d          = '0;
				state_d        = S_SSTEP;
			end
			S_SSTEP: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(SQRT_STEPS - 1))
					state_d = S_SWRITE;
			end
			S_SWRITE: begin
				cmd.sqrt_write = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			seq_q       <= SEQ_CMUL;
			act_q       <= ACT_ADD;
			pow_rem_q   <= '0;
			exp_neg_q   <= 1'b0;
			part_im_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			seq_q     <= seq_d;
			act_q     <= act_d;
			pow_rem_q <= pow_rem_d;
			exp_neg_q <= exp_neg_d;
			part_im_q <= part_im_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`CAU_ASSERT_NEXT(a_accept_drops_ready, clk, arst_n, in_valid && in_ready, !in_ready)
	`CAU_ASSERT_IMPLIES(a_emit_into_free_slot, clk, arst_n, cmd.emit, !out_valid_q || out_ready)
	`CAU_ASSERT_NEXT(a_emit_sets_valid, clk, arst_n, cmd.emit, out_valid_q)

endmodule

FILE: sv/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit.
`timescale 1ns / 1ps

// Complex arithmetic unit: takes one transaction of two Q16.16 complex operands, an action
// code and a signed exponent, and returns one transaction with the sum, difference, product,
// quotient, magnitude of the first operand, or its integer power (zero for an unknown action
// code), rounded to nearest and saturated, with a status of ok, division by zero or overflow.
// One transaction is worked on at a time. A single 32x32 multiplier builds all products one
// per cycle, a one-bit restoring divider gives each quotient part bit by bit and the square
// root is also found bit by bit. Power is a chain of complex multiplications plus a division
// when the exponent is negative; FRAC_BITS gives the fraction width, 16 for Q16.16. The result
// waits in an output register, so the next transaction is taken while it is still held.

module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int unsigned MAX_EXPONENT = 31,
	parameter int unsigned FRAC_BITS    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // a_re, a_im, b_re, b_im, exponent, zero pad
	input  logic [2:0]   s_axis_tuser,  // action
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // r_re, r_im
	output logic [1:0]   m_axis_tuser   // status
);

	cau_cmd_t                 cmd;
	cau_stat_t                stat;
	logic signed [WORD_W-1:0] r_re, r_im;

	cau_controller #(
		.MAX_EXPONENT(MAX_EXPONENT),
		.FRAC_BITS   (FRAC_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_action  (s_axis_tuser),
		.in_exponent(s_axis_tdata[133:128]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.cmd        (cmd),
		.stat       (stat)
	);

	cau_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat),
		.a_re  (s_axis_tdata[31:0]),
		.a_im  (s_axis_tdata[63:32]),
		.b_re  (s_axis_tdata[95:64]),
		.b_im  (s_axis_tdata[127:96]),
		.r_re  (r_re),
		.r_im  (r_im),
		.status(m_axis_tuser)
	);

	assign m_axis_tdata = {r_im, r_re};

endmodule

FILE: verif/complex_arithmetic_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit with a fixed-point predictor.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
	import cau_pkg::*;

	localparam int FRAC = 16;
	localparam int MAX_EXP = 31;

	typedef struct {
		logic [ACT_W-1:0]  action;
		logic signed [31:0] a_re, a_im, b_re, b_im;
		logic signed [5:0]  exponent;
	} cplx_op_t;

	typedef struct {
		logic signed [31:0] r_re, r_im;
		logic [STAT_W-1:0]  status;
	} cplx_res_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;  // a_re, a_im, b_re, b_im, exponent, zero pad
	logic [2:0]   s_axis_tuser = '0;  // action
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;       // r_re, r_im
	logic [1:0]   m_axis_tuser;       // status

	cplx_op_t  pending_ops[$];
	cplx_res_t expected_results[$];
	cplx_op_t  cur_op;
	bit        in_fire = 1'b0;
	bit        calm = 1'b0;
	int        errors = 0;

	complex_arithmetic_unit i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Round n/d to nearest, ties away from zero, and saturate to 32 bits.
	function automatic logic signed [31:0] div_round_sat(input logic signed [127:0] n,
			input logic [127:0] d, inout bit ovf);
		logic [127:0] m, q, r, lim;
		bit neg;
		neg = n < 0;
		m = neg ? -n : n;
		q = m / d;
		r = m % d;
		if (r >= d - r)
			q = q + 1;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) begin
			ovf = 1'b1;
			q = lim;
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic void cplx_mul(input logic signed [31:0] xr, xi, yr, yi,
			output logic signed [31:0] rr, ri, inout bit ovf);
		logic signed [127:0] re, im;
		re = 128'(xr) * 128'(yr) - 128'(xi) * 128'(yi);
		im = 128'(xr) * 128'(yi) + 128'(xi) * 128'(yr);
		rr = div_round_sat(re, 128'(1) << FRAC, ovf);
		ri = div_round_sat(im, 128'(1) << FRAC, ovf);
	endfunction

	// Returns 1 when the divisor is zero.
	function automatic bit cplx_div(input logic signed [31:0] xr, xi, yr, yi,
			output logic signed [31:0] rr, ri, inout bit ovf);
		logic signed [127:0] re, im;
		logic [127:0] d;
		rr = 0;
		ri = 0;
		d = 128'(128'(yr) * 128'(yr) + 128'(yi) * 128'(yi));
		if (d == 0)
			return 1'b1;
		re = (128'(xr) * 128'(yr) + 128'(xi) * 128'(yi)) <<< FRAC;
		im = (128'(xi) * 128'(yr) - 128'(xr) * 128'(yi)) <<< FRAC;
		rr = div_round_sat(re, d, ovf);
		ri = div_round_sat(im, d, ovf);
		return 1'b0;
	endfunction

	function automatic cplx_res_t predict_result(input cplx_op_t op);
		cplx_res_t res;
		logic signed [63:0] sum;
		logic [127:0] sq, root, cand;
		logic signed [31:0] tr, ti;
		int mag;
		bit ovf, dz;
		ovf = 1'b0;
		dz = 1'b0;
		res.r_re = 0;
		res.r_im = 0;
		case (op.action)
			ACT_ADD, ACT_SUB: begin
				for (int k = 0; k < 2; k++) begin
					if (op.action == ACT_ADD)
						sum = k ? 64'(op.a_im) + 64'(op.b_im) : 64'(op.a_re) + 64'(op.b_re);
					else
						sum = k ? 64'(op.a_im) - 64'(op.b_im) : 64'(op.a_re) - 64'(op.b_re);
					if (sum > 64'sh7fff_ffff) begin
						ovf = 1'b1;
						sum = 64'sh7fff_ffff;
					end else if (sum < -64'sh8000_0000) begin
						ovf = 1'b1;
						sum = -64'sh8000_0000;
					end
					if (k) res.r_im = sum[31:0];
					else   res.r_re = sum[31:0];
				end
			end
			ACT_MUL: cplx_mul(op.a_re, op.a_im, op.b_re, op.b_im, res.r_re, res.r_im, ovf);
			ACT_DIV: dz = cplx_div(op.a_re, op.a_im, op.b_re, op.b_im, res.r_re, res.r_im, ovf);
			ACT_MAG: begin
				sq = 128'(op.a_re) * 128'(op.a_re) + 128'(op.a_im) * 128'(op.a_im);
				root = 0;
				for (int i = 33; i >= 0; i--) begin
					cand = root | (128'(1) << i);
					if (cand * cand <= sq)
						root = cand;
				end
				if (root > 128'h7fff_ffff) begin
					ovf = 1'b1;
					root = 128'h7fff_ffff;
				end
				res.r_re = root[31:0];
			end
			ACT_POW: begin
				mag = op.exponent < 0 ? -int'(op.exponent) : int'(op.exponent);
				if (mag > MAX_EXP)
					mag = MAX_EXP;
				if (mag == 0) begin
					res.r_re = 32'sd1 << FRAC;
				end else begin
					tr = op.a_re;
					ti = op.a_im;
					for (int k = 1; k < mag; k++)
						cplx_mul(tr, ti, op.a_re, op.a_im, tr, ti, ovf);
					if (op.exponent < 0)
						dz = cplx_div(32'sd1 << FRAC, 0, tr, ti, res.r_re, res.r_im, ovf);
					else begin
						res.r_re = tr;
						res.r_im = ti;
					end
				end
			end
			default: ;
		endcase
		if (dz) begin
			res.r_re = 0;
			res.r_im = 0;
		end
		res.status = dz ? ST_DIV_ZERO : (ovf ? ST_OVERFLOW : ST_OK);
		return res;
	endfunction

	function automatic logic signed [31:0] rand_word(input int flavour);
		case (flavour)
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
				: -32'sh8000_0000 + $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic void push_op(input logic [ACT_W-1:0] act,
			input logic signed [31:0] ar, ai, br, bi, input logic signed [5:0] e);
		cplx_op_t op;
		op.action = act;
		op.a_re = ar;
		op.a_im = ai;
		op.b_re = br;
		op.b_im = bi;
		op.exponent = e;
		pending_ops.push_back(op);
	endfunction

	// Stimulus, reset and end of run.
	initial begin
		int wait_cycles;
		int act;
		logic signed [31:0] ar, ai;
		push_op(ACT_ADD, 32'sh7fff_ffff, -32'sh8000_0000, 32'sd1, -32'sd1, 0);
		push_op(ACT_ADD, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000, 0);
		push_op(ACT_SUB, -32'sh8000_0000, 32'sh7fff_ffff, 32'sd1, -32'sd1, 0);
		push_op(ACT_SUB, 32'sh0001_8000, 0, 32'sh0000_8000, 32'sh0001_0000, 0);
		push_op(ACT_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, -32'sh8000_0000, 0);
		push_op(ACT_MUL, 32'sh0001_8000, -32'sh0000_8000, 32'sh0002_0000, 32'sd1, 0);
		push_op(ACT_MUL, 32'sd1, 32'sd1, 32'sh0000_8000, 32'sh0000_8000, 0);
		push_op(ACT_DIV, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0);
		push_op(ACT_DIV, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000, 0);
		push_op(ACT_DIV, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd1, 0, 0);
		push_op(ACT_DIV, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, 0);
		push_op(ACT_MAG, -32'sh8000_0000, -32'sh8000_0000, 0, 0, 0);
		push_op(ACT_MAG, 32'sh0003_0000, -32'sh0004_0000, 32'sd5, 32'sd5, 0);
		push_op(ACT_MAG, 0, 0, 0, 0, 0);
		push_op(ACT_POW, 32'sh0001_8000, 32'sh0000_4000, 0, 0, 0);
		push_op(ACT_POW, 32'sh0001_0000, 32'sh0000_1000, 0, 0, 6'sd31);
		push_op(ACT_POW, 32'sh0001_0000, 32'sh0000_1000, 0, 0, -6'sd32);
		push_op(ACT_POW, 32'sh0000_8000, 32'sh0000_8000, 0, 0, -6'sd3);
		push_op(ACT_POW, 32'sh0000_0100, 0, 0, 0, -6'sd4);
		push_op(ACT_POW, 32'sh0010_0000, 0, 0, 0, 6'sd9);
		push_op(3'd6, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 6'sd1);
		push_op(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -6'sd1);
		for (int n = 0; n < 1300; n++) begin
			act = $urandom_range(0, 99);
			act = act < 96 ? act % 6 : 6 + act % 2;
			if (act == ACT_POW) begin
				// keep the base near unity so long powers neither vanish nor saturate at once
				ar = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
				ai = $signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000;
				if ($urandom_range(0, 9) == 0) begin
					ar = rand_word($urandom_range(0, 3));
					ai = rand_word($urandom_range(0, 3));
				end
				push_op(ACT_W'(act), ar, ai, rand_word(0), rand_word(0), EXP_W'($urandom));
			end else begin
				push_op(ACT_W'(act), rand_word($urandom_range(0, 3)),
					rand_word($urandom_range(0, 3)),
					$urandom_range(0, 15) ? rand_word($urandom_range(0, 3)) : 0,
					$urandom_range(0, 15) ? rand_word($urandom_range(0, 3)) : 0,
					EXP_W'($urandom));
			end
		end
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_ops.size() < 900);
		calm = 1'b1;
		wait (pending_ops.size() < 700);
		calm = 1'b0;
		wait (pending_ops.size() == 0 && !s_axis_tvalid);
		wait (expected_results.size() == 0);
		wait_cycles = 0;
		while (wait_cycles < 400) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (errors == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#12ms;
		$display("status: fail");
		$finish;
	end

	// Source side: present the next transaction after the previous one is taken.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
				cur_op = pending_ops.pop_front();
				s_axis_tdata <= {2'b00, cur_op.exponent, cur_op.b_im, cur_op.b_re,
					cur_op.a_im, cur_op.a_re};
				s_axis_tuser <= cur_op.action;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		if (arst_n)
			m_axis_tready <= calm || $urandom_range(0, 99) >= 23;
	end

	// Sample both handshakes; predict on input, compare on output.
	always @(posedge clk) begin
		cplx_res_t exp_res;
		in_fire = s_axis_tvalid && s_axis_tready;
		if (in_fire)
			expected_results.push_back(predict_result(cur_op));
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				exp_res = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== exp_res.r_re) begin
					$error("r_re expected %0d actual %0d", exp_res.r_re,
						$signed(m_axis_tdata[31:0]));
					errors++;
				end
				if (m_axis_tdata[63:32] !== exp_res.r_im) begin
					$error("r_im expected %0d actual %0d", exp_res.r_im,
						$signed(m_axis_tdata[63:32]));
					errors++;
				end
				if (m_axis_tuser !== exp_res.status) begin
					$error("status expected %0d actual %0d", exp_res.status, m_axis_tuser);
					errors++;
				end
			end
		end
	end

endmodule
